// File: hdl/ssnf_pkg.sv
// Shared constants, types, the glyph function and the place clamp for the seven-segment number formatter.
`default_nettype none
package ssnf_pkg;

    localparam int MAX_DIGITS = 8;
    localparam int PW         = $clog2(MAX_DIGITS + 1);
    localparam int DIW        = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int BIN_W      = 32;
    localparam int DEC_DIGITS = 10;
    localparam int BUF_DIGITS = (MAX_DIGITS > DEC_DIGITS) ? MAX_DIGITS : DEC_DIGITS;
    localparam int BUF_W      = BUF_DIGITS * 4;
    localparam int NDW        = $clog2(BUF_DIGITS + 1);
    localparam int CW         = $clog2(BIN_W);
    localparam int DC_W       = 4;
    localparam int CFG_W      = 4;
    localparam int POS_W      = 3;
    localparam int SEG_W      = 8;
    localparam int Q_DEPTH    = 2;
    localparam int QAW        = $clog2(Q_DEPTH);
    localparam int QCW        = $clog2(Q_DEPTH + 1);

    localparam logic CFG_IDX_DIGIT_COUNT   = 1'b0;
    localparam logic CFG_IDX_LEADING_ZEROS = 1'b1;

    localparam logic ACT_DEC = 1'b0;
    localparam logic ACT_HEX = 1'b1;

    localparam logic [DC_W-1:0]  DC_RESET  = 4'd4;
    localparam logic [SEG_W-1:0] PAT_MINUS = 8'h40;
    localparam logic [SEG_W-1:0] PAT_BLANK = 8'h00;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } t_front_state;

    // One converted number waiting for display.
    typedef struct packed {
        logic [MAX_DIGITS-1:0][3:0] digits;
        logic [PW-1:0]              shown;
        logic                       neg;
        logic                       trunc;
    } t_rec;

    function automatic logic [SEG_W-1:0] glyph(input logic [3:0] d);
        logic [SEG_W-1:0] g;
        case (d)
            4'h0: g = 8'h3F;
            4'h1: g = 8'h06;
            4'h2: g = 8'h5B;
            4'h3: g = 8'h4F;
            4'h4: g = 8'h66;
            4'h5: g = 8'h6D;
            4'h6: g = 8'h7D;
            4'h7: g = 8'h07;
            4'h8: g = 8'h7F;
            4'h9: g = 8'h6F;
            4'hA: g = 8'h77;
            4'hB: g = 8'h7C;
            4'hC: g = 8'h39;
            4'hD: g = 8'h5E;
            4'hE: g = 8'h79;
            4'hF: g = 8'h71;
            default: g = PAT_BLANK;
        endcase
        return g;
    endfunction

    // Clamp the configured count into 1..MAX_DIGITS.
    function automatic logic [PW-1:0] places(input logic [DC_W-1:0] dc);
        logic [PW-1:0] p;
        if (dc == '0) begin
            p = PW'(1);
        end else if (int'(dc) > MAX_DIGITS) begin
            p = PW'(MAX_DIGITS);
        end else begin
            p = PW'(dc);
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// File: hdl/ssnf_front.sv
// Front end: takes a number, converts it to digits and measures the field it needs.
`default_nettype none
module ssnf_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic                          i_action,
    input  wire logic [ssnf_pkg::BIN_W-1:0]    i_value,
    input  wire logic [ssnf_pkg::PW-1:0]       i_places,
    output logic                               o_q_push,
    output ssnf_pkg::t_rec                     o_rec,
    input  wire logic                          i_q_full
);

    ssnf_pkg::t_front_state              r_state, n_state;
    logic [ssnf_pkg::CW-1:0]             r_cnt, n_cnt;
    logic [ssnf_pkg::BIN_W-1:0]          r_bin, n_bin;
    logic [ssnf_pkg::BUF_W-1:0]          r_bcd, n_bcd;
    logic                                r_neg, n_neg;
    logic [ssnf_pkg::NDW-1:0]            nd;
    logic                                over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssnf_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    always_comb begin
        logic [ssnf_pkg::BUF_W-1:0] adj;
        logic                       neg;
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        adj     = r_bcd;
        neg     = 1'b0;
        case (r_state)
            ssnf_pkg::FR_IDLE: begin
                if (i_push) begin
                    neg   = (i_action == ssnf_pkg::ACT_DEC) && i_value[ssnf_pkg::BIN_W-1];
                    n_neg = neg;
                    n_bin = neg ? (ssnf_pkg::BIN_W'(0) - i_value) : i_value;
                    n_cnt = '0;
                    n_bcd = '0;
                    if (i_action == ssnf_pkg::ACT_HEX) begin
                        // Hex digits are the nibbles themselves.
                        n_bcd[ssnf_pkg::BIN_W-1:0] = i_value;
                        n_state = ssnf_pkg::FR_PUSH;
                    end else begin
                        n_state = ssnf_pkg::FR_CONV;
                    end
                end
            end
            ssnf_pkg::FR_CONV: begin
                // Shift-and-add-3: one binary bit enters the BCD register per cycle.
                for (int i = 0; i < ssnf_pkg::BUF_DIGITS; i++) begin
                    if (r_bcd[i*4 +: 4] >= 4'd5) begin
                        adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
                    end
                end
                n_bcd = {adj[ssnf_pkg::BUF_W-2:0], r_bin[ssnf_pkg::BIN_W-1]};
                n_bin = {r_bin[ssnf_pkg::BIN_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ssnf_pkg::CW'(ssnf_pkg::BIN_W - 1)) begin
                    n_state = ssnf_pkg::FR_PUSH;
                end
            end
            ssnf_pkg::FR_PUSH: begin
                if (!i_q_full) begin
                    n_state = ssnf_pkg::FR_IDLE;
                end
            end
            default: begin
                n_state = ssnf_pkg::FR_IDLE;
            end
        endcase
    end

    // Significant digit count, at least one so that zero shows a single '0'.
    always_comb begin
        nd = ssnf_pkg::NDW'(1);
        for (int i = 0; i < ssnf_pkg::BUF_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) begin
                nd = ssnf_pkg::NDW'(i + 1);
            end
        end
    end

    assign over         = int'(nd) > int'(i_places);
    assign o_rec.digits = r_bcd[ssnf_pkg::MAX_DIGITS*4-1:0];
    assign o_rec.shown  = over ? i_places : ssnf_pkg::PW'(nd);
    assign o_rec.neg    = r_neg;
    assign o_rec.trunc  = over || (r_neg && (o_rec.shown == i_places));
    assign o_q_push     = (r_state == ssnf_pkg::FR_PUSH) && !i_q_full;
    assign o_full       = (r_state != ssnf_pkg::FR_IDLE);

endmodule
`default_nettype wire

// File: hdl/ssnf_queue.sv
// Short record queue between the converter and the place emitter.
`default_nettype none
module ssnf_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ssnf_pkg::t_rec   i_rec,
    output logic                  o_full,
    input  wire logic             i_pop,
    output ssnf_pkg::t_rec        o_rec,
    output logic                  o_empty
);

    ssnf_pkg::t_rec                r_mem [ssnf_pkg::Q_DEPTH];
    logic [ssnf_pkg::QAW-1:0]      r_wp;
    logic [ssnf_pkg::QAW-1:0]      r_rp;
    logic [ssnf_pkg::QCW-1:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == ssnf_pkg::QAW'(ssnf_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == ssnf_pkg::QAW'(ssnf_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    assign o_rec   = r_mem[r_rp];
    assign o_full  = (r_cnt == ssnf_pkg::QCW'(ssnf_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule
`default_nettype wire

// File: hdl/ssnf_back.sv
// Back end: walks the places left to right and drives the result register.
`default_nettype none
module ssnf_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_empty,
    input  wire ssnf_pkg::t_rec                i_rec,
    output logic                               o_q_pop,
    input  wire logic [ssnf_pkg::PW-1:0]       i_places,
    input  wire logic                          i_lz,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [ssnf_pkg::POS_W-1:0]         o_position,
    output logic [ssnf_pkg::SEG_W-1:0]         o_segments,
    output logic                               o_truncated,
    output logic                               o_last
);

    logic [ssnf_pkg::PW-1:0]       r_k;
    logic                          r_out_valid;
    logic [ssnf_pkg::POS_W-1:0]    r_out_pos;
    logic [ssnf_pkg::SEG_W-1:0]    r_out_seg;
    logic                          r_out_trunc;
    logic                          r_out_last;

    logic                          advance;
    logic                          go;
    logic                          at_last;
    logic [ssnf_pkg::PW-1:0]       j;
    logic [ssnf_pkg::PW-1:0]       m;
    logic                          is_digit;
    logic                          minus_fits;
    logic [ssnf_pkg::SEG_W-1:0]    seg;

    assign advance    = !r_out_valid || i_pop;
    assign go         = advance && !i_q_empty;
    assign at_last    = (r_k == i_places - 1'b1);
    assign j          = i_places - 1'b1 - r_k;
    assign m          = i_places - 1'b1 - i_rec.shown;
    assign is_digit   = (j < i_rec.shown);
    assign minus_fits = i_rec.neg && (i_rec.shown < i_places);

    always_comb begin
        if (is_digit) begin
            seg = ssnf_pkg::glyph(i_rec.digits[j[ssnf_pkg::DIW-1:0]]);
        end else if (minus_fits) begin
            if (i_lz) begin
                seg = (r_k == '0) ? ssnf_pkg::PAT_MINUS : ssnf_pkg::glyph(4'd0);
            end else begin
                seg = (r_k == m) ? ssnf_pkg::PAT_MINUS : ssnf_pkg::PAT_BLANK;
            end
        end else begin
            seg = i_lz ? ssnf_pkg::glyph(4'd0) : ssnf_pkg::PAT_BLANK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                r_out_valid <= 1'b1;
                r_k         <= at_last ? '0 : r_k + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_pos   <= ssnf_pkg::POS_W'(r_k);
            r_out_seg   <= seg;
            r_out_trunc <= i_rec.trunc;
            r_out_last  <= at_last;
        end
    end

    assign o_q_pop     = go && at_last;
    assign o_empty     = !r_out_valid;
    assign o_position  = r_out_pos;
    assign o_segments  = r_out_seg;
    assign o_truncated = r_out_trunc;
    assign o_last      = r_out_last;

`ifndef SYNTH
    a_k_in_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_k) < int'(i_places))
        else $error("place counter left the field");

    a_last_is_rightmost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_pos == ssnf_pkg::POS_W'(i_places - 1'b1))
        else $error("last flag off the rightmost place");

    a_places_run_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop && r_out_valid && !r_out_last |=> r_out_valid && $stable(r_out_trunc))
        else $error("places of one number did not follow each other");
`endif

endmodule
`default_nettype wire

// File: hdl/seven_segment_number_formatter_top.sv
// Top level of the seven-segment number formatter: config registers and the two halves.
// Flow: a decimal item goes through the 32-step shift-and-add-3 converter, a hex item
//   skips it; each record then passes the queue and the emitter's output register.
// Intake: the front holds full until its record is pushed, so it takes one item at a
//   time; the emitter gives one place per cycle while a record waits and the receiver pops.
// Reset: synchronous, active low; clears control state, digit count to 4, no zero fill.
`default_nettype none
module seven_segment_number_formatter_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input item queue side
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_action,
    input  wire logic [ssnf_pkg::BIN_W-1:0]    i_value,
    // result queue side
    output logic                               empty,
    input  wire logic                          pop,
    output logic [ssnf_pkg::POS_W-1:0]         o_position,
    output logic [ssnf_pkg::SEG_W-1:0]         o_segments,
    output logic                               o_truncated,
    output logic                               o_last,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [ssnf_pkg::CFG_W-1:0]    i_cfg_data
);

    logic [ssnf_pkg::DC_W-1:0]    r_digit_count;
    logic                         r_leading_zeros;
    logic [ssnf_pkg::PW-1:0]      places;

    logic                         q_push;
    logic                         q_full;
    logic                         q_pop;
    logic                         q_empty;
    ssnf_pkg::t_rec               front_rec;
    ssnf_pkg::t_rec               head_rec;

    // Always accepted; the user must change configuration only while idle, unenforced.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count   <= ssnf_pkg::DC_RESET;
            r_leading_zeros <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssnf_pkg::CFG_IDX_DIGIT_COUNT: begin
                    r_digit_count <= i_cfg_data[ssnf_pkg::DC_W-1:0];
                end
                ssnf_pkg::CFG_IDX_LEADING_ZEROS: begin
                    r_leading_zeros <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the place count once; both halves use the same field width.
    assign places = ssnf_pkg::places(r_digit_count);

    // Converter: magnitude, sign and digit count of each number.
    ssnf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_action (i_action),
        .i_value  (i_value),
        .i_places (places),
        .o_q_push (q_push),
        .o_rec    (front_rec),
        .i_q_full (q_full)
    );

    // Decouple the converter from the emitter so each can stall on its own.
    ssnf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rec   (head_rec),
        .o_empty (q_empty)
    );

    // Emitter: one result per place, left to right, through the output register.
    ssnf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_rec       (head_rec),
        .o_q_pop     (q_pop),
        .i_places    (places),
        .i_lz        (r_leading_zeros),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_position  (o_position),
        .o_segments  (o_segments),
        .o_truncated (o_truncated),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

// File: bench/ssnf_checker.sv
// Checker for the seven-segment number formatter: predicts each place and compares results.
`timescale 1ns / 1ps
module ssnf_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic                          i_full,
    input  wire logic                          i_action,
    input  wire logic [ssnf_pkg::BIN_W-1:0]    i_value,
    input  wire logic                          i_empty,
    input  wire logic                          i_pop,
    input  wire logic [ssnf_pkg::POS_W-1:0]    i_position,
    input  wire logic [ssnf_pkg::SEG_W-1:0]    i_segments,
    input  wire logic                          i_truncated,
    input  wire logic                          i_last,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [ssnf_pkg::CFG_W-1:0]    i_cfg_data,
    output int                                 o_errors,
    output int                                 o_outstanding
);

    localparam int PRINT_CAP = 40;

    // Segment patterns for hex digits, index 0 at the low end.
    localparam logic [15:0][7:0] DIGIT_FONT = {
        8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed {
        logic [ssnf_pkg::POS_W-1:0] position;
        logic [ssnf_pkg::SEG_W-1:0] segments;
        logic                       truncated;
        logic                       last;
    } t_place;

    t_place                      expected_places[$];
    logic [ssnf_pkg::DC_W-1:0]   digit_count;
    logic                        zero_fill;
    int                          error_count;

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
        error_count   = 0;
        digit_count   = ssnf_pkg::DC_RESET;
        zero_fill     = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Expand one number into its display places, left to right.
    function automatic void predict_places(input logic hex,
                                           input logic [ssnf_pkg::BIN_W-1:0] raw);
        logic [ssnf_pkg::SEG_W-1:0] pat [ssnf_pkg::MAX_DIGITS];
        logic [ssnf_pkg::BIN_W-1:0] mag;
        logic                       neg;
        logic                       trunc;
        int                         n;
        int                         pos;
        t_place                     pl;
        if (digit_count == '0) begin
            n = 1;
        end else if (int'(digit_count) > ssnf_pkg::MAX_DIGITS) begin
            n = ssnf_pkg::MAX_DIGITS;
        end else begin
            n = int'(digit_count);
        end
        for (int k = 0; k < ssnf_pkg::MAX_DIGITS; k++) begin
            pat[k] = ssnf_pkg::PAT_BLANK;
        end
        mag   = raw;
        neg   = 1'b0;
        trunc = 1'b0;
        if (hex != ssnf_pkg::ACT_HEX && raw[ssnf_pkg::BIN_W-1]) begin
            neg = 1'b1;
            mag = -raw;
        end
        pos = n - 1;
        if (mag == '0) begin
            pat[pos] = DIGIT_FONT[0];
            pos--;
        end else begin
            while (mag != '0 && pos >= 0) begin
                if (hex == ssnf_pkg::ACT_HEX) begin
                    pat[pos] = DIGIT_FONT[mag[3:0]];
                    mag      = mag >> 4;
                end else begin
                    pat[pos] = DIGIT_FONT[4'(mag % 10)];
                    mag      = mag / 10;
                end
                pos--;
            end
            if (mag != '0) begin
                trunc = 1'b1;
            end
        end
        // pos now points at the rightmost blank place, -1 if none
        if (neg) begin
            if (pos < 0) begin
                trunc = 1'b1;
            end else if (zero_fill) begin
                pat[0] = ssnf_pkg::PAT_MINUS;
                for (int k = 1; k <= pos; k++) begin
                    pat[k] = DIGIT_FONT[0];
                end
            end else begin
                pat[pos] = ssnf_pkg::PAT_MINUS;
            end
        end else if (zero_fill) begin
            for (int k = 0; k <= pos; k++) begin
                pat[k] = DIGIT_FONT[0];
            end
        end
        for (int k = 0; k < n; k++) begin
            pl.position  = ssnf_pkg::POS_W'(k);
            pl.segments  = pat[k];
            pl.truncated = trunc;
            pl.last      = (k == n - 1);
            expected_places.push_back(pl);
        end
    endfunction

    always @(posedge i_clk) begin
        t_place want;
        if (!i_rst_n) begin
            expected_places.delete();
            digit_count = ssnf_pkg::DC_RESET;
            zero_fill   = 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == ssnf_pkg::CFG_IDX_DIGIT_COUNT) begin
                    digit_count = i_cfg_data[ssnf_pkg::DC_W-1:0];
                end else begin
                    zero_fill = i_cfg_data[0];
                end
            end
            if (i_pop && !i_empty) begin
                if (expected_places.size() == 0) begin
                    report_mismatch($sformatf("unexpected place pos=%0d seg=%02h",
                                              i_position, i_segments));
                end else begin
                    want = expected_places.pop_front();
                    if (i_position !== want.position) begin
                        report_mismatch($sformatf("position got %0d want %0d",
                                                  i_position, want.position));
                    end
                    if (i_segments !== want.segments) begin
                        report_mismatch($sformatf("segments at place %0d got %02h want %02h",
                                                  want.position, i_segments, want.segments));
                    end
                    if (i_truncated !== want.truncated) begin
                        report_mismatch($sformatf("truncated at place %0d got %0b want %0b",
                                                  want.position, i_truncated, want.truncated));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch($sformatf("last at place %0d got %0b want %0b",
                                                  want.position, i_last, want.last));
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_places(i_action, i_value);
            end
        end
        o_errors      <= error_count;
        o_outstanding <= expected_places.size();
    end

endmodule

// File: bench/tb_seven_segment_number_formatter_top.sv
// Testbench top for the seven-segment number formatter: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_seven_segment_number_formatter_top;

    localparam int ITEMS_PER_PHASE = 60;
    localparam int PHASES          = 8;
    localparam int HOLD_CYCLES     = 250;
    localparam int SETTLE_CYCLES   = 60;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           push       = 1'b0;
    logic                           full;
    logic                           action     = ssnf_pkg::ACT_DEC;
    logic [ssnf_pkg::BIN_W-1:0]     value      = '0;
    logic                           empty;
    logic                           pop        = 1'b0;
    logic [ssnf_pkg::POS_W-1:0]     position;
    logic [ssnf_pkg::SEG_W-1:0]     segments;
    logic                           truncated;
    logic                           last;
    logic                           cfg_valid  = 1'b0;
    logic                           cfg_ready;
    logic                           cfg_index  = ssnf_pkg::CFG_IDX_DIGIT_COUNT;
    logic [ssnf_pkg::CFG_W-1:0]     cfg_data   = '0;

    int                 errors;
    int                 outstanding;
    // no_idle: both sides run flat out; hold_pop: receiver backs off for a long stretch
    logic               no_idle    = 1'b0;
    logic               hold_pop   = 1'b0;

    always #10 clk = ~clk;

    seven_segment_number_formatter_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_action    (action),
        .i_value     (value),
        .empty       (empty),
        .pop         (pop),
        .o_position  (position),
        .o_segments  (segments),
        .o_truncated (truncated),
        .o_last      (last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ssnf_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_action      (action),
        .i_value       (value),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_position    (position),
        .i_segments    (segments),
        .i_truncated   (truncated),
        .i_last        (last),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    // Pick an idle gap: none under no_idle, else mostly none, sometimes short, rarely long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 9);
        if (no_idle || r < 6) begin
            return 0;
        end else if (r < 9) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Draw a value, leaning toward the corners of both display modes.
    function automatic logic [ssnf_pkg::BIN_W-1:0] pick_value();
        logic [ssnf_pkg::BIN_W-1:0] corners [14];
        corners = '{32'h0, 32'h1, 32'h9, 32'hA, 32'd99999999, 32'd100000000,
                    32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'hFFFFFFFF,
                    32'hFFFFFFF6, 32'h0FFFFFFF, 32'h10000000, 32'hF0000000};
        case ($urandom_range(0, 5))
            0:       return corners[$urandom_range(0, 13)];
            1:       return ssnf_pkg::BIN_W'($urandom_range(0, 99));
            2:       return -ssnf_pkg::BIN_W'($urandom_range(1, 9999));
            3:       return ssnf_pkg::BIN_W'($urandom_range(0, 99999999));
            default: return $urandom();
        endcase
    endfunction

    // Offer one item after an optional gap and hold it until taken.
    // Leave push high on return so back-to-back items need no extra edge.
    task automatic send_item(input logic act, input logic [ssnf_pkg::BIN_W-1:0] val);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        action <= act;
        value  <= val;
        do @(posedge clk); while (full);
    endtask

    // Drop push and wait until every predicted place has been popped.
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Write both registers back to back; the block must be idle here.
    task automatic write_settings(input logic [ssnf_pkg::CFG_W-1:0] dc,
                                  input logic [ssnf_pkg::CFG_W-1:0] lz);
        cfg_valid <= 1'b1;
        cfg_index <= ssnf_pkg::CFG_IDX_DIGIT_COUNT;
        cfg_data  <= dc;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= ssnf_pkg::CFG_IDX_LEADING_ZEROS;
        cfg_data  <= lz;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random pop bursts, with a long hold-off whenever one is requested.
    initial begin
        int  len;
        int  r;
        logic level;
        forever begin
            if (hold_pop) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pop = 1'b0;
            end else begin
                r = $urandom_range(0, 9);
                if (no_idle) begin
                    level = 1'b1;
                    len   = 1;
                end else if (r < 6) begin
                    level = 1'b1;
                    len   = $urandom_range(1, 8);
                end else if (r < 9) begin
                    level = 1'b0;
                    len   = $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    len   = $urandom_range(10, 40);
                end
                repeat (len) begin
                    pop <= level;
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: bounds the whole run of roughly 520 items, each with conversion, stalled places and gaps.
    initial begin
        #30_000_000;
        $display("** seven_segment_number_formatter_top: FAILED **");
        $finish;
    end

    initial begin
        logic [ssnf_pkg::CFG_W-1:0] dc;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings (4 places, blanks): zero, fit, overflow, minus cases.
        send_item(ssnf_pkg::ACT_DEC, 32'd0);
        send_item(ssnf_pkg::ACT_DEC, 32'd1234);
        send_item(ssnf_pkg::ACT_DEC, 32'd12345);
        send_item(ssnf_pkg::ACT_DEC, -32'd123);
        send_item(ssnf_pkg::ACT_DEC, -32'd1234);
        send_item(ssnf_pkg::ACT_HEX, 32'hFFFFFFFF);
        send_item(ssnf_pkg::ACT_HEX, 32'h0);
        send_item(ssnf_pkg::ACT_DEC, 32'h80000000);
        drain();

        // Full width with zero fill: minus goes leftmost, zeros fill between.
        write_settings(4'd8, 4'h1);
        send_item(ssnf_pkg::ACT_DEC, -32'd5);
        send_item(ssnf_pkg::ACT_DEC, 32'h80000000);
        send_item(ssnf_pkg::ACT_HEX, 32'hDEADBEEF);
        send_item(ssnf_pkg::ACT_DEC, 32'd7);
        send_item(ssnf_pkg::ACT_DEC, 32'd0);
        drain();

        // Count of zero acts as one place; minus never fits there.
        write_settings(4'd0, 4'hE);
        send_item(ssnf_pkg::ACT_DEC, 32'd0);
        send_item(ssnf_pkg::ACT_DEC, -32'd3);
        send_item(ssnf_pkg::ACT_HEX, 32'hA);
        drain();

        // Count above the maximum clamps to full width.
        write_settings(4'd15, 4'h0);
        send_item(ssnf_pkg::ACT_DEC, 32'h7FFFFFFF);
        send_item(ssnf_pkg::ACT_HEX, 32'h12345678);
        send_item(ssnf_pkg::ACT_DEC, -32'd1234567);
        drain();

        // Random phases, each under its own settings; the first four hit the extremes.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       dc = 4'd1;
                1:       dc = 4'd8;
                2:       dc = 4'd0;
                3:       dc = 4'd15;
                default: dc = ssnf_pkg::CFG_W'($urandom_range(0, 15));
            endcase
            write_settings(dc, ssnf_pkg::CFG_W'($urandom_range(0, 15)));
            no_idle = (p == 4);
            if (p == 5) begin
                // Stall the receiver and offer sixteen hex items back to back so that the input backs up.
                hold_pop = 1'b1;
                no_idle  = 1'b1;
                repeat (16) send_item(ssnf_pkg::ACT_HEX, $urandom());
                no_idle  = 1'b0;
                drain();
            end
            repeat (ITEMS_PER_PHASE) send_item(logic'($urandom_range(0, 1)), pick_value());
            drain();
        end
        no_idle = 1'b0;

        // Let any stray place show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0) begin
            $display("** seven_segment_number_formatter_top: PASSED **");
        end else begin
            $display("** seven_segment_number_formatter_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/ssnf_pkg.sv
hdl/ssnf_front.sv
hdl/ssnf_queue.sv
hdl/ssnf_back.sv
hdl/seven_segment_number_formatter_top.sv
bench/ssnf_checker.sv
bench/tb_seven_segment_number_formatter_top.sv
